>>> hdl/greyscale_metalness_map_defines.svh
// ----------------------------------------------------------------------------
// Greyscale metalness map assertion macros
// Concurrent assertion helpers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef GREYSCALE_METALNESS_MAP_DEFINES_SVH
`define GREYSCALE_METALNESS_MAP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled in reset.
`define GMM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("greyscale_metalness_map: same-cycle check failed");
// Next-cycle implication, clocked on clk and disabled in reset.
`define GMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("greyscale_metalness_map: next-cycle check failed");
`else
`define GMM_ASSERT_IMP(label, ante, cons)
`define GMM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/gmm_pkg.sv
// ----------------------------------------------------------------------------
// Greyscale metalness map package
// Shared widths, constants, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package gmm_pkg;

    localparam int GREY_W   = 9;
    localparam int SCALED_W = 12;

    localparam logic [15:0] LUMA_WR    = 16'd19589;
    localparam logic [15:0] LUMA_WG    = 16'd38470;
    localparam logic [15:0] LUMA_WB    = 16'd7471;
    localparam logic [7:0]  FULL_LEVEL = 8'd255;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BIAS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BINARY_METAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_LEVEL  = 3'd5;

    typedef struct packed {
        logic               source_select;
        logic [14:0]        scale_factor;
        logic signed [8:0]  level_bias;
        logic               binary_metal;
        logic               cutoff_enable;
        logic [7:0]         cutoff_level;
    } cfg_t;

endpackage

>>> hdl/gmm_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one albedo RGB triple and a displacement.
// ----------------------------------------------------------------------------
interface gmm_pix_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] displacement;

    modport source (output valid, output red, output green, output blue,
                    output displacement, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input displacement, output ready);
endinterface

>>> hdl/gmm_res_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying the level and metal bytes of one pixel.
// ----------------------------------------------------------------------------
interface gmm_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic [7:0] metal;

    modport source (output valid, output level, output metal, input ready);
    modport sink   (input valid, input level, input metal, output ready);
endinterface

>>> hdl/gmm_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for the six control registers.
// ----------------------------------------------------------------------------
module gmm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [gmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmm_pkg::CFG_DATA_W-1:0] cfg_data,
    output gmm_pkg::cfg_t                 cfg
);
    import gmm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_SELECT: cfg_next.source_select = cfg_data[0];
                REG_SCALE_FACTOR:  cfg_next.scale_factor  = cfg_data[14:0];
                REG_LEVEL_BIAS:    cfg_next.level_bias    = $signed(cfg_data[8:0]);
                REG_BINARY_METAL:  cfg_next.binary_metal  = cfg_data[0];
                REG_CUTOFF_ENABLE: cfg_next.cutoff_enable = cfg_data[0];
                REG_CUTOFF_LEVEL:  cfg_next.cutoff_level  = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_select <= 1'b0;
            cfg_reg.scale_factor  <= 15'd4096;
            cfg_reg.level_bias    <= 9'sd0;
            cfg_reg.binary_metal  <= 1'b0;
            cfg_reg.cutoff_enable <= 1'b0;
            cfg_reg.cutoff_level  <= FULL_LEVEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/gmm_grey.sv
// ----------------------------------------------------------------------------
// Grey source stage
// Forms the luma of the RGB triple or the scaled displacement, registered.
// ----------------------------------------------------------------------------
module gmm_grey (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       source_select,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic [16:0]                displacement,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gmm_pkg::GREY_W-1:0] grey
);
    import gmm_pkg::*;

    logic              valid_reg;
    logic [GREY_W-1:0] grey_reg;
    logic [GREY_W-1:0] grey_next;
    logic [23:0]       luma_sum;
    logic [24:0]       disp_prod;
    logic              advance;

    // Luma weights sum to just under 65536, so the sum fits 24 bits.
    assign luma_sum  = 24'(red) * 24'(LUMA_WR) + 24'(green) * 24'(LUMA_WG)
                     + 24'(blue) * 24'(LUMA_WB);
    assign disp_prod = 25'(displacement) * 25'(FULL_LEVEL);

    always_comb
    begin
        if (source_select)
            grey_next = disp_prod[24:16];
        else
            grey_next = {1'b0, luma_sum[23:16]};
    end

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            grey_reg <= grey_next;
    end

    assign out_valid = valid_reg;
    assign grey      = grey_reg;

endmodule

>>> hdl/gmm_scale.sv
// ----------------------------------------------------------------------------
// Scale stage
// Multiplies the grey value by the 1/4096 scale and truncates, registered.
// ----------------------------------------------------------------------------
module gmm_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [14:0]                  scale_factor,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [gmm_pkg::GREY_W-1:0]   grey,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gmm_pkg::SCALED_W-1:0] scaled
);
    import gmm_pkg::*;

    logic                valid_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [23:0]         product;
    logic                advance;

    assign product  = 24'(grey) * 24'(scale_factor);
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            scaled_reg <= product[23:12];
    end

    assign out_valid = valid_reg;
    assign scaled    = scaled_reg;

endmodule

>>> hdl/gmm_level.sv
// ----------------------------------------------------------------------------
// Level and metal stage
// Adds the bias, clamps to a byte and applies the cutoff and binary modes.
// ----------------------------------------------------------------------------
module gmm_level (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gmm_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [gmm_pkg::SCALED_W-1:0] scaled,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   level,
    output logic [7:0]                   metal
);
    import gmm_pkg::*;

    logic               valid_reg;
    logic [7:0]         level_reg;
    logic [7:0]         metal_reg;
    logic [7:0]         level_next;
    logic [7:0]         metal_next;
    logic signed [13:0] biased;
    logic               below;
    logic               advance;

    assign biased = $signed({2'b00, scaled}) + 14'(cfg.level_bias);

    always_comb
    begin
        priority if (biased < 14'sd0)
            level_next = 8'd0;
        else if (biased > $signed({6'd0, FULL_LEVEL}))
            level_next = FULL_LEVEL;
        else
            level_next = biased[7:0];
    end

    assign below = cfg.cutoff_level > level_next;

    always_comb
    begin
        priority if (cfg.cutoff_enable && cfg.binary_metal)
            metal_next = below ? FULL_LEVEL : 8'd0;
        else if (cfg.cutoff_enable)
            metal_next = below ? level_next : 8'd0;
        else if (cfg.binary_metal)
            metal_next = (level_next != 8'd0) ? FULL_LEVEL : 8'd0;
        else
            metal_next = level_next;
    end

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            level_reg <= level_next;
            metal_reg <= metal_next;
        end
    end

    assign out_valid = valid_reg;
    assign level     = level_reg;
    assign metal     = metal_reg;

endmodule

>>> hdl/greyscale_metalness_map.sv
// A pixel beat is registered in turn by the grey source, scale and level stages.
// Throughput: one pixel per cycle unless stalled; each of the three stages (grey source,
// scale multiplier, bias/clamp/metal) holds one beat and refills as it drains.
// The last stage register is the output register, so a stalled result does
// not block earlier stages from filling their empty slots.
// Reset (rst_n, async, active low) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// Greyscale metalness map
// Streams pixels into an 8-bit level (roughness) and a metalness byte.
// ----------------------------------------------------------------------------
`include "greyscale_metalness_map_defines.svh"

module greyscale_metalness_map (
    input  logic                          clk,
    input  logic                          rst_n,
    gmm_pix_if.sink                       pix,
    gmm_res_if.source                     res,
    input  logic                          cfg_write,
    input  logic [gmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gmm_pkg::*;

    cfg_t                cfg;
    logic                grey_valid;
    logic                grey_ready;
    logic [GREY_W-1:0]   grey;
    logic                scaled_valid;
    logic                scaled_ready;
    logic [SCALED_W-1:0] scaled;

    gmm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gmm_grey u_grey (
        .clk           (clk),
        .rst_n         (rst_n),
        .source_select (cfg.source_select),
        .in_valid      (pix.valid),
        .in_ready      (pix.ready),
        .red           (pix.red),
        .green         (pix.green),
        .blue          (pix.blue),
        .displacement  (pix.displacement),
        .out_valid     (grey_valid),
        .out_ready     (grey_ready),
        .grey          (grey)
    );

    gmm_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale_factor (cfg.scale_factor),
        .in_valid     (grey_valid),
        .in_ready     (grey_ready),
        .grey         (grey),
        .out_valid    (scaled_valid),
        .out_ready    (scaled_ready),
        .scaled       (scaled)
    );

    gmm_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (scaled_valid),
        .in_ready  (scaled_ready),
        .scaled    (scaled),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .level     (res.level),
        .metal     (res.metal)
    );

    // In binary mode the metal byte is either fully off or fully on.
    `GMM_ASSERT_IMP(a_binary_metal, res.valid && cfg.binary_metal, res.metal == 8'd0 || res.metal == FULL_LEVEL)
    // With cutoff on, any nonzero metal means the level sat below the cutoff.
    `GMM_ASSERT_IMP(a_cutoff_metal, res.valid && cfg.cutoff_enable && res.metal != 8'd0, res.level < cfg.cutoff_level)
    // With both modes off, metal follows the level exactly.
    `GMM_ASSERT_IMP(a_plain_metal, res.valid && !cfg.cutoff_enable && !cfg.binary_metal, res.metal == res.level)
    // A cutoff write lands in the register on the next cycle.
    `GMM_ASSERT_NEXT(a_cutoff_write, cfg_write && cfg_index == REG_CUTOFF_LEVEL, cfg.cutoff_level == $past(cfg_data[7:0]))

endmodule
